[rtl/gfa_pkg.sv]
// Shared types and constants for the GF(2^m) polynomial-basis ALU.
// Used by gfa_mul, gfa_seq and galois_field_alu; depends on nothing.
package gfa_pkg;

   localparam int FIELD_DEGREE = 8;
   localparam int ELEM_W       = FIELD_DEGREE;
   localparam int MOD_W        = FIELD_DEGREE + 1;

   localparam logic [MOD_W-1:0] MODULUS_RESET = MOD_W'(283);

   typedef logic [ELEM_W-1:0] elem_type;
   typedef logic [MOD_W-1:0]  modulus_type;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SEARCH,
      ST_FINAL
   } state_type;

   // sequencer -> datapath
   typedef struct packed {
      logic sel_cand_x;   // multiplier x input takes the trial candidate
      logic sel_cand_y;   // multiplier y input takes the found inverse
      logic rsp_load;     // capture a result into the output register
      logic rsp_err;      // result is an error (value forced to zero)
      logic rsp_xor;      // result is a ^ b rather than the product
   } ctrl_type;

   // datapath -> sequencer
   typedef struct packed {
      logic       start;
      opcode_type op;
      logic       divisor_zero;
      logic       prod_one;
   } status_type;

endpackage

[rtl/galois_field_alu.sv]
// Top level of the GF(2^8) polynomial-basis ALU: operand, modulus and result
// registers around the shared multiplier. Depends on gfa_pkg, gfa_mul, gfa_seq.
//
//  channel  | ports                                     | transfer when
//  ---------+-------------------------------------------+---------------------
//  request  | start, busy, req_opcode/operand_a/b       | start && !busy
//  response | rsp_strobe, rsp_result_value/error_flag   | rsp_strobe (1 cycle)
//  csr      | csr_valid, csr_ready, csr_modulus_poly    | csr_valid && csr_ready
//
// Add, subtract, multiply, divide by zero: EXEC loads the result, and the strobe
// is registered from that load. Divide: one multiplier pass per trial candidate
// from zero in SEARCH; FINAL loads a times the found inverse, or an error loads
// if a nonzero divisor has none. busy drops in the strobe cycle, so the next
// request may transfer then. Synchronous reset restores modulus x^8+x^4+x^3+x+1.
// The receiver cannot stall; each result shows for exactly one cycle.
module galois_field_alu (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [1:0]           req_opcode,
   input  gfa_pkg::elem_type    req_operand_a,
   input  gfa_pkg::elem_type    req_operand_b,
   output logic                 rsp_strobe,
   output gfa_pkg::elem_type    rsp_result_value,
   output logic                 rsp_error_flag,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  gfa_pkg::modulus_type csr_modulus_poly
);

   gfa_pkg::opcode_type  op_ff;
   gfa_pkg::elem_type    a_ff, b_ff;
   gfa_pkg::modulus_type modulus_ff;
   logic                 rsp_strobe_ff;
   gfa_pkg::elem_type    rsp_value_ff, rsp_value_in;
   logic                 rsp_error_ff;

   gfa_pkg::ctrl_type    ctrl;
   gfa_pkg::status_type  status;
   gfa_pkg::elem_type    cand;
   gfa_pkg::elem_type    mul_x, mul_y, product;
   logic                 accept;

   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= gfa_pkg::opcode_type'(req_opcode);
         a_ff  <= req_operand_a;
         b_ff  <= req_operand_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= gfa_pkg::MODULUS_RESET;
      end else if (csr_valid && csr_ready) begin
         modulus_ff <= csr_modulus_poly;
      end
   end

   assign mul_x = ctrl.sel_cand_x ? cand : a_ff;
   assign mul_y = ctrl.sel_cand_y ? cand : b_ff;

   gfa_mul u_mul (
      .x        (mul_x),
      .y        (mul_y),
      .poly_low (modulus_ff[gfa_pkg::ELEM_W-1:0]),
      .product  (product)
   );

   assign status.start        = start;
   assign status.op           = op_ff;
   assign status.divisor_zero = (b_ff == '0);
   assign status.prod_one     = (product == gfa_pkg::ELEM_W'(1));

   gfa_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl),
      .cand   (cand),
      .busy   (busy)
   );

   always_comb begin
      if (ctrl.rsp_err) begin
         rsp_value_in = '0;
      end else if (ctrl.rsp_xor) begin
         rsp_value_in = a_ff ^ b_ff;
      end else begin
         rsp_value_in = product;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= ctrl.rsp_load;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.rsp_load) begin
         rsp_value_ff <= rsp_value_in;
         rsp_error_ff <= ctrl.rsp_err;
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_error_flag   = rsp_error_ff;

`ifndef NO_ASSERTIONS
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result strobe without a request in flight");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_error_flag) |-> (rsp_result_value == '0))
      else $error("error result carries a nonzero value");

   a_error_only_divide: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_error_flag) |-> (op_ff == gfa_pkg::OP_DIV))
      else $error("error flagged on a non-divide operation");

   a_fast_ops_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_opcode != gfa_pkg::OP_DIV)) |-> ##2 rsp_strobe)
      else $error("add, subtract or multiply result late");
`endif

endmodule

[rtl/gfa_mul.sv]
// Shared GF(2^m) multiplier: carry-less product reduced by a monic modulus.
// Depends on gfa_pkg for element widths.
module gfa_mul (
   input  gfa_pkg::elem_type x,
   input  gfa_pkg::elem_type y,
   input  gfa_pkg::elem_type poly_low,
   output gfa_pkg::elem_type product
);

   // MSB-first Horner form: multiply by x and reduce, then add x if y bit set
   always_comb begin
      gfa_pkg::elem_type acc;
      acc = '0;
      for (int i = gfa_pkg::ELEM_W - 1; i >= 0; i--) begin
         acc = {acc[gfa_pkg::ELEM_W-2:0], 1'b0}
             ^ (acc[gfa_pkg::ELEM_W-1] ? poly_low : '0)
             ^ (y[i] ? x : '0);
      end
      product = acc;
   end

endmodule

[rtl/gfa_seq.sv]
// Sequencer: runs one item through the shared multiplier or the a ^ b path,
// including the trial-inverse search for divide. Depends on gfa_pkg.
module gfa_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  gfa_pkg::status_type  status,
   output gfa_pkg::ctrl_type    ctrl,
   output gfa_pkg::elem_type    cand,
   output logic                 busy
);

   gfa_pkg::state_type state_ff, state_in;
   gfa_pkg::elem_type  cand_ff, cand_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gfa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff <= cand_in;
   end

   always_comb begin
      state_in = state_ff;
      cand_in  = cand_ff;
      ctrl     = '0;
      case (state_ff)
         gfa_pkg::ST_IDLE: begin
            if (status.start) begin
               state_in = gfa_pkg::ST_EXEC;
            end
         end
         gfa_pkg::ST_EXEC: begin
            case (status.op)
               gfa_pkg::OP_ADD, gfa_pkg::OP_SUB: begin
                  ctrl.rsp_load = 1'b1;
                  ctrl.rsp_xor  = 1'b1;
                  state_in      = gfa_pkg::ST_IDLE;
               end
               gfa_pkg::OP_MUL: begin
                  ctrl.rsp_load = 1'b1;
                  state_in      = gfa_pkg::ST_IDLE;
               end
               default: begin
                  if (status.divisor_zero) begin
                     ctrl.rsp_load = 1'b1;
                     ctrl.rsp_err  = 1'b1;
                     state_in      = gfa_pkg::ST_IDLE;
                  end else begin
                     cand_in  = '0;
                     state_in = gfa_pkg::ST_SEARCH;
                  end
               end
            endcase
         end
         gfa_pkg::ST_SEARCH: begin
            ctrl.sel_cand_x = 1'b1;
            if (status.prod_one) begin
               // hold the candidate: it is the inverse
               state_in = gfa_pkg::ST_FINAL;
            end else if (&cand_ff) begin
               ctrl.rsp_load = 1'b1;
               ctrl.rsp_err  = 1'b1;
               state_in      = gfa_pkg::ST_IDLE;
            end else begin
               cand_in = cand_ff + 1'b1;
            end
         end
         gfa_pkg::ST_FINAL: begin
            ctrl.sel_cand_y = 1'b1;
            ctrl.rsp_load   = 1'b1;
            state_in        = gfa_pkg::ST_IDLE;
         end
         default: begin
            state_in = gfa_pkg::ST_IDLE;
         end
      endcase
   end

   assign cand = cand_ff;
   assign busy = (state_ff != gfa_pkg::ST_IDLE);

endmodule
